// ===== hw/rtl/gise_pkg.sv =====
package gise_pkg;

  // Field widths
  localparam int GAIN_W       = 7;
  localparam int SUBFRAMES    = 4;
  localparam int MSG_BITS_MAX = 4;
  localparam int MSG_W        = 4;
  localparam int LEN_W        = 4;
  localparam int SUB_W        = 3;
  localparam int CNT_W        = 3;
  localparam int COST_W       = 4;
  localparam int SQ_W         = 5;
  localparam int DIGIT_W      = 3;
  localparam int K_W          = 2;

  // Stream packing, lowest bit first
  localparam int SUB_LSB      = SUBFRAMES * GAIN_W;
  localparam int MBITS_LSB    = SUB_LSB + SUB_W;
  localparam int MLEN_LSB     = MBITS_LSB + MSG_W;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - SUBFRAMES * GAIN_W - MSG_W - CNT_W;

  // APB
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  // Offset digit: index 0..4 stands for offset -2..+2
  localparam logic [DIGIT_W-1:0] DIGIT_LAST = 3'd4;

  typedef enum logic [1:0] {
    REG_LIMIT_ABS  = 2'd0,
    REG_LIMIT_COND = 2'd1,
    REG_MAX_COST   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SWEEP,
    ST_PARITY,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] limit_abs;
    logic [GAIN_W-1:0] limit_cond;
    logic [COST_W-1:0] max_cost;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic parity_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic matrix;
    logic empty;
    logic sweep_last;
    logic parity_end;
  } sts_t;

  // Absolute offset of a digit
  function automatic logic [1:0] digit_abs(input logic [DIGIT_W-1:0] idx);
    logic [1:0] r;
    case (idx)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Squared offset of a digit
  function automatic logic [2:0] digit_sq(input logic [DIGIT_W-1:0] idx);
    logic [2:0] r;
    case (idx)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd0;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gain_index_stego_embed.sv =====
// Channel | Direction | Payload
// s_*     | in        | s_tdata: gain_0..gain_3, subframe_count, message_bits, message_length;
//         |           | s_tuser: conditional_coding
// m_*     | out       | m_tdata: new_gain_0..new_gain_3, applied_bits, applied_count
// APB     | in/out    | gain_limit_absolute @0x0, gain_limit_conditional @0x4, max_cost @0x8
//
// Matrix mode runs load, dispatch, sweep and result, testing one offset candidate per cycle
// in the sweep over all 625 offset combinations.
// Parity mode handles one subframe per cycle; zero-length frames go from dispatch to result.
// A new frame is taken once the previous one sits in the output register.
// Reset is asynchronous, active low; a stalled output holds the engine in its final state.
module gain_index_stego_embed (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [6:0] gain_0, [13:7] gain_1, [20:14] gain_2, [27:21] gain_3,
  // [30:28] subframe_count, [34:31] message_bits, [38:35] message_length
  input  logic [gise_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] conditional_coding
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [6:0] new_gain_0, [13:7] new_gain_1, [20:14] new_gain_2, [27:21] new_gain_3,
  // [31:28] applied_bits, [34:32] applied_count
  output logic [gise_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gise_pkg::APB_AW-1:0]      paddr,
  input  logic [gise_pkg::APB_DW-1:0]      pwdata,
  output logic [gise_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import gise_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  gise_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gise_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gise_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg),
    .in_data_i  (s_tdata),
    .in_cond_i  (s_tuser),
    .out_data_o (m_tdata)
  );

endmodule

// ===== hw/rtl/gise_regs.sv =====
module gise_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gise_pkg::APB_AW-1:0] paddr,
  input  logic [gise_pkg::APB_DW-1:0] pwdata,
  output logic [gise_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output gise_pkg::cfg_t             cfg_o
);
  import gise_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LIMIT_ABS:  cfg_d.limit_abs  = pwdata[GAIN_W-1:0];
        REG_LIMIT_COND: cfg_d.limit_cond = pwdata[GAIN_W-1:0];
        REG_MAX_COST:   cfg_d.max_cost   = pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_LIMIT_ABS:  prdata = APB_DW'(cfg_q.limit_abs);
      REG_LIMIT_COND: prdata = APB_DW'(cfg_q.limit_cond);
      REG_MAX_COST:   prdata = APB_DW'(cfg_q.max_cost);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_abs  <= 7'd63;
      cfg_q.limit_cond <= 7'd40;
      cfg_q.max_cost   <= 4'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/gise_ctrl.sv =====
module gise_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  gise_pkg::sts_t sts_i,
  output gise_pkg::cmd_t cmd_o
);
  import gise_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts_i.empty)       state_d = ST_FINISH;
        else if (sts_i.matrix) state_d = ST_SWEEP;
        else                   state_d = ST_PARITY;
      end
      ST_SWEEP:    if (sts_i.sweep_last) state_d = ST_FINISH;
      ST_PARITY:   if (sts_i.parity_end) state_d = ST_FINISH;
      ST_FINISH:   if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
      end
      ST_SWEEP:  cmd_o.sweep_step  = 1'b1;
      ST_PARITY: cmd_o.parity_step = 1'b1;
      ST_FINISH: cmd_o.finish      = slot_free;
      default: ;
    endcase
  end

  // Hold the result until the output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/gise_dpath.sv =====
module gise_dpath (
  input  logic                             clk_i,
  input  gise_pkg::cmd_t                   cmd_i,
  output gise_pkg::sts_t                   sts_o,
  input  gise_pkg::cfg_t                   cfg_i,
  input  logic [gise_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                             in_cond_i,
  output logic [gise_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import gise_pkg::*;

  // Frame registers
  logic [GAIN_W-1:0]  g_q      [SUBFRAMES];
  logic [GAIN_W-1:0]  lim_q;
  logic [MSG_W-1:0]   bits_q;
  logic [CNT_W-1:0]   nbits_q;
  logic               matrix_q;

  // Sweep registers
  logic [DIGIT_W-1:0] dig_q    [SUBFRAMES];
  logic [GAIN_W-1:0]  best_g_q [SUBFRAMES];
  logic               found_q;
  logic [COST_W-1:0]  best_c1_q;
  logic [SQ_W-1:0]    best_c2_q;

  // Parity registers
  logic [GAIN_W-1:0]  res_g_q  [SUBFRAMES];
  logic [MSG_W-1:0]   app_bits_q;
  logic [CNT_W-1:0]   app_n_q;
  logic [K_W-1:0]     k_q;

  logic [OUT_TDATA_W-1:0] out_q;

  // Load-time decode
  logic [SUB_W-1:0]  ld_sub;
  logic [LEN_W-1:0]  ld_len;
  logic [CNT_W-1:0]  ld_nb;
  logic              ld_matrix;

  always_comb begin
    ld_sub    = in_data_i[SUB_LSB +: SUB_W];
    ld_len    = in_data_i[MLEN_LSB +: LEN_W];
    ld_matrix = (ld_sub >= SUB_W'(SUBFRAMES));
    ld_nb     = (ld_len > LEN_W'(MSG_BITS_MAX)) ? CNT_W'(MSG_BITS_MAX) : ld_len[CNT_W-1:0];
    if (!ld_matrix && (ld_nb > ld_sub)) ld_nb = ld_sub;
  end

  // Evaluate the current candidate
  logic signed [GAIN_W+1:0] cand [SUBFRAMES];
  logic [SUBFRAMES-1:0]     in_rng;
  logic [COST_W-1:0]        c1;
  logic [SQ_W-1:0]          c2;
  logic [9:0]               sym_full;
  logic [MSG_W-1:0]         mask, target, sym;
  logic                     hit, better, sweep_last;

  always_comb begin
    c1         = '0;
    c2         = '0;
    sweep_last = 1'b1;
    for (int k = 0; k < SUBFRAMES; k++) begin
      cand[k]   = $signed({2'b00, g_q[k]}) + $signed({6'b0, dig_q[k]}) - 9'sd2;
      in_rng[k] = !cand[k][GAIN_W+1] && (cand[k][GAIN_W:0] <= {1'b0, lim_q});
      c1        = c1 + COST_W'(digit_abs(dig_q[k]));
      c2        = c2 + SQ_W'(digit_sq(dig_q[k]));
      sweep_last = sweep_last && (dig_q[k] == DIGIT_LAST);
    end
    sym_full = 10'(cand[0][3:0]) + 10'(cand[1][3:0]) * 10'd3 +
               10'(cand[2][3:0]) * 10'd9 + 10'(cand[3][3:0]) * 10'd27;
    mask     = MSG_W'((5'd1 << nbits_q) - 5'd1);
    target   = bits_q & mask;
    sym      = sym_full[MSG_W-1:0] & mask;
    hit      = (&in_rng) && (sym == target);
    better   = !found_q || (c1 < best_c1_q) || ((c1 == best_c1_q) && (c2 < best_c2_q));
  end

  // Advance the offset counter, last digit fastest
  logic [DIGIT_W-1:0] dig_next [SUBFRAMES];
  logic               carry;

  always_comb begin
    carry = 1'b1;
    for (int k = SUBFRAMES - 1; k >= 0; k--) begin
      dig_next[k] = dig_q[k];
      if (carry) begin
        if (dig_q[k] == DIGIT_LAST) begin
          dig_next[k] = '0;
        end else begin
          dig_next[k] = dig_q[k] + 3'd1;
          carry       = 1'b0;
        end
      end
    end
  end

  // Parity step on one subframe
  logic [GAIN_W-1:0] p_cur, p_pick;
  logic [GAIN_W:0]   p_up;
  logic              p_want, p_ok, parity_end;

  always_comb begin
    p_cur  = res_g_q[k_q];
    p_want = bits_q[k_q];
    p_up   = {1'b0, p_cur} + 8'd1;
    p_pick = p_cur;
    p_ok   = 1'b0;
    if (p_cur[0] == p_want) begin
      p_ok   = (p_cur <= lim_q);
    end else if ((p_cur != '0) && ((p_cur - 7'd1) <= lim_q)) begin
      p_pick = p_cur - 7'd1;
      p_ok   = 1'b1;
    end else if (p_up <= {1'b0, lim_q}) begin
      p_pick = p_up[GAIN_W-1:0];
      p_ok   = 1'b1;
    end
    parity_end = !p_ok || ({1'b0, k_q} == (nbits_q - 3'd1));
  end

  // Result selection
  logic                take;
  logic [GAIN_W-1:0]   fin_g [SUBFRAMES];
  logic [MSG_W-1:0]    fin_bits;
  logic [CNT_W-1:0]    fin_n;

  always_comb begin
    take = found_q && (best_c1_q <= cfg_i.max_cost);
    for (int k = 0; k < SUBFRAMES; k++) begin
      if (matrix_q) fin_g[k] = take ? best_g_q[k] : g_q[k];
      else          fin_g[k] = res_g_q[k];
    end
    if (matrix_q) begin
      fin_bits = take ? target : '0;
      fin_n    = take ? nbits_q : '0;
    end else begin
      fin_bits = app_bits_q;
      fin_n    = app_n_q;
    end
  end

  // Registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < SUBFRAMES; k++) begin
        g_q[k]     <= in_data_i[k*GAIN_W +: GAIN_W];
        res_g_q[k] <= in_data_i[k*GAIN_W +: GAIN_W];
        dig_q[k]   <= '0;
      end
      lim_q      <= in_cond_i ? cfg_i.limit_cond : cfg_i.limit_abs;
      bits_q     <= in_data_i[MBITS_LSB +: MSG_W];
      nbits_q    <= ld_nb;
      matrix_q   <= ld_matrix;
      found_q    <= 1'b0;
      app_bits_q <= '0;
      app_n_q    <= '0;
      k_q        <= '0;
    end
    if (cmd_i.sweep_step) begin
      for (int k = 0; k < SUBFRAMES; k++) dig_q[k] <= dig_next[k];
      if (hit && better) begin
        found_q   <= 1'b1;
        best_c1_q <= c1;
        best_c2_q <= c2;
        for (int k = 0; k < SUBFRAMES; k++) best_g_q[k] <= cand[k][GAIN_W-1:0];
      end
    end
    if (cmd_i.parity_step && p_ok) begin
      res_g_q[k_q]    <= p_pick;
      app_bits_q[k_q] <= p_want;
      app_n_q         <= app_n_q + 3'd1;
      k_q             <= k_q + 2'd1;
    end
    if (cmd_i.finish) begin
      out_q <= {{OUT_PAD_W{1'b0}}, fin_n, fin_bits, fin_g[3], fin_g[2], fin_g[1], fin_g[0]};
    end
  end

  assign sts_o.matrix     = matrix_q;
  assign sts_o.empty      = (nbits_q == '0);
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.parity_end = parity_end;
  assign out_data_o       = out_q;

endmodule
